// ===== design/pgw_pkg.sv =====
// Shared types, constants and codes for the two-level page walk unit.
package pgw_pkg;

   localparam int PAGE_COUNT_DEFAULT = 128;
   localparam int PAGE_BYTES         = 32;
   localparam int OFFSET_BITS        = $clog2(PAGE_BYTES);
   localparam int PAGE_NUM_BITS      = 7;
   localparam int PAGE_NUM_RANGE     = 2 ** PAGE_NUM_BITS;

   localparam int CMD_BITS     = 2;
   localparam int VADDR_BITS   = 15;
   localparam int WADDR_BITS   = 12;
   localparam int BYTE_BITS    = 8;
   localparam int STATUS_BITS  = 2;
   localparam int DIR_IDX_BITS = 5;
   localparam int PADDR_BITS   = 12;

   localparam int ENTRY_VALID_BIT = 7;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_WORD_LSB  = 2;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - CSR_WORD_LSB;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DIRECTORY_BASE = '0;
   localparam logic [PAGE_NUM_BITS-1:0]  DIRECTORY_BASE_RESET = 7'h6c;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TRANSLATE    = 2'd0,
      CMD_WRITE_MEMORY = 2'd1,
      CMD_WRITE_DISK   = 2'd2,
      CMD_UNUSED       = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_FAULT   = 2'd0,
      STATUS_MEMORY  = 2'd1,
      STATUS_DISK    = 2'd2,
      STATUS_WRITTEN = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIRECTORY,
      ST_TABLE,
      ST_DATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 write_en;
      logic                 read_en;
      logic [BYTE_BITS-1:0] wdata;
   } ram_ctl_type;

endpackage

// ===== design/pgw_channels.sv =====
// Request and response channel interfaces of the page walk unit.
interface pgw_req_if;
   logic                               valid;
   logic                               ready;
   logic [pgw_pkg::CMD_BITS-1:0]       cmd;
   logic [pgw_pkg::VADDR_BITS-1:0]     virt_address;
   logic [pgw_pkg::WADDR_BITS-1:0]     write_address;
   logic [pgw_pkg::BYTE_BITS-1:0]      write_data;

   modport source (output valid, cmd, virt_address, write_address, write_data, input ready);
   modport sink   (input valid, cmd, virt_address, write_address, write_data, output ready);
endinterface

interface pgw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pgw_pkg::STATUS_BITS-1:0]    status;
   logic [pgw_pkg::DIR_IDX_BITS-1:0]   directory_index;
   logic [pgw_pkg::PAGE_NUM_BITS-1:0]  table_page;
   logic [pgw_pkg::PAGE_NUM_BITS-1:0]  frame_number;
   logic [pgw_pkg::PADDR_BITS-1:0]     phys_address;
   logic [pgw_pkg::BYTE_BITS-1:0]      data_value;

   modport source (output valid, status, directory_index, table_page, frame_number,
                   phys_address, data_value, input ready);
   modport sink   (input valid, status, directory_index, table_page, frame_number,
                   phys_address, data_value, output ready);
endinterface

// ===== design/two_level_page_walk_unit.sv =====
// Top level of the two-level page walk unit.
//
//   channel        direction  protocol       contents
//   req_channel    in         valid/ready    cmd, virt_address, write_address, write_data
//   rsp_channel    out        valid/ready    status, indices, frame, address, data byte
//   csr_*          in/out     APB-style      directory_base_page at byte address 0
//
// A translation steps through accept, three dependent reads of the registered-read
// memories (directory, table, data), then response load in ST_DONE. A directory fault
// goes from the directory read straight to the response load, and a memory or disk write
// goes from accept to the response load; the unused command is dropped in its accept cycle.
// Requests are taken one at a time.
// Synchronous reset clears the sequencer, the response valid and the base register; the
// memory contents are not cleared. A stalled response holds the walk in its final state.
module two_level_page_walk_unit #(
   parameter int PAGE_COUNT = pgw_pkg::PAGE_COUNT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   pgw_req_if.sink                            req_channel,
   pgw_rsp_if.source                          rsp_channel,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pgw_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pgw_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pgw_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   localparam int PAGE_BITS = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int ADDR_BITS = PAGE_BITS + pgw_pkg::OFFSET_BITS;
   localparam int DEPTH     = PAGE_COUNT * pgw_pkg::PAGE_BYTES;

   logic [pgw_pkg::PAGE_NUM_BITS-1:0] directory_base_page;
   pgw_pkg::ram_ctl_type              mem_ctl;
   pgw_pkg::ram_ctl_type              disk_ctl;
   logic [ADDR_BITS-1:0]              mem_addr;
   logic [ADDR_BITS-1:0]              disk_addr;
   logic [pgw_pkg::BYTE_BITS-1:0]     mem_rdata;
   logic [pgw_pkg::BYTE_BITS-1:0]     disk_rdata;

   pgw_csr u_csr (
      .clock               (clock),
      .reset               (reset),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready),
      .directory_base_page (directory_base_page)
   );

   pgw_ram #(
      .DEPTH     (DEPTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_phys_memory (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .rdata (mem_rdata)
   );

   pgw_ram #(
      .DEPTH     (DEPTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_disk_store (
      .clock (clock),
      .ctl   (disk_ctl),
      .addr  (disk_addr),
      .rdata (disk_rdata)
   );

   pgw_walker #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_walker (
      .clock               (clock),
      .reset               (reset),
      .directory_base_page (directory_base_page),
      .req                 (req_channel),
      .rsp                 (rsp_channel),
      .mem_ctl             (mem_ctl),
      .mem_addr            (mem_addr),
      .mem_rdata           (mem_rdata),
      .disk_ctl            (disk_ctl),
      .disk_addr           (disk_addr),
      .disk_rdata          (disk_rdata)
   );

endmodule

// ===== design/pgw_ram.sv =====
// Byte-wide single-port synchronous RAM with registered read data.
module pgw_ram #(
   parameter int DEPTH     = pgw_pkg::PAGE_COUNT_DEFAULT * pgw_pkg::PAGE_BYTES,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                           clock,
   input  pgw_pkg::ram_ctl_type           ctl,
   input  logic [ADDR_BITS-1:0]           addr,
   output logic [pgw_pkg::BYTE_BITS-1:0]  rdata
);

   logic [pgw_pkg::BYTE_BITS-1:0] mem [DEPTH];
   logic [pgw_pkg::BYTE_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.write_en) begin
         mem[addr] <= ctl.wdata;
      end
      if (ctl.read_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/pgw_csr.sv =====
// Configuration register file holding the directory base page.
module pgw_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pgw_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pgw_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pgw_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output logic [pgw_pkg::PAGE_NUM_BITS-1:0]  directory_base_page
);

   logic [pgw_pkg::PAGE_NUM_BITS-1:0]  base_ff;
   logic [pgw_pkg::PAGE_NUM_BITS-1:0]  base_in;
   logic [pgw_pkg::CSR_INDEX_BITS-1:0] reg_index;
   logic                               write_strobe;

   assign csr_pready   = 1'b1;
   assign reg_index    = csr_paddr[pgw_pkg::CSR_ADDR_BITS-1:pgw_pkg::CSR_WORD_LSB];
   assign write_strobe = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      base_in    = base_ff;
      csr_prdata = '0;
      unique case (reg_index)
         pgw_pkg::REG_DIRECTORY_BASE: begin
            csr_prdata = pgw_pkg::CSR_DATA_BITS'(base_ff);
            if (write_strobe) begin
               base_in = csr_pwdata[pgw_pkg::PAGE_NUM_BITS-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= pgw_pkg::DIRECTORY_BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   assign directory_base_page = base_ff;

endmodule

// ===== design/pgw_walker.sv =====
// Walk sequencer: issues directory, table and data reads and holds the response register.
module pgw_walker #(
   parameter int PAGE_COUNT = pgw_pkg::PAGE_COUNT_DEFAULT,
   localparam int PAGE_BITS = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
   localparam int ADDR_BITS = PAGE_BITS + pgw_pkg::OFFSET_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pgw_pkg::PAGE_NUM_BITS-1:0]  directory_base_page,
   pgw_req_if.sink                            req,
   pgw_rsp_if.source                          rsp,
   output pgw_pkg::ram_ctl_type               mem_ctl,
   output logic [ADDR_BITS-1:0]               mem_addr,
   input  logic [pgw_pkg::BYTE_BITS-1:0]      mem_rdata,
   output pgw_pkg::ram_ctl_type               disk_ctl,
   output logic [ADDR_BITS-1:0]               disk_addr,
   input  logic [pgw_pkg::BYTE_BITS-1:0]      disk_rdata
);

   localparam int OB = pgw_pkg::OFFSET_BITS;
   localparam int PN = pgw_pkg::PAGE_NUM_BITS;

   // page number to store page, reduced modulo the page count
   logic [PAGE_BITS-1:0] page_map [pgw_pkg::PAGE_NUM_RANGE];

   for (genvar i = 0; i < pgw_pkg::PAGE_NUM_RANGE; i++) begin : g_page_map
      assign page_map[i] = PAGE_BITS'(i % PAGE_COUNT);
   end

   pgw_pkg::state_type                state_ff, state_in;
   logic [pgw_pkg::VADDR_BITS-1:0]    va_ff, va_in;
   logic [PN-1:0]                     pt_ff, pt_in;
   logic [PN-1:0]                     pfn_ff, pfn_in;
   logic                              resident_ff, resident_in;
   pgw_pkg::status_type               status_ff, status_in;
   logic [pgw_pkg::BYTE_BITS-1:0]     data_ff, data_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   pgw_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [pgw_pkg::DIR_IDX_BITS-1:0]  rsp_dir_ff, rsp_dir_in;
   logic [PN-1:0]                     rsp_pt_ff, rsp_pt_in;
   logic [PN-1:0]                     rsp_pfn_ff, rsp_pfn_in;
   logic [pgw_pkg::PADDR_BITS-1:0]    rsp_paddr_ff, rsp_paddr_in;
   logic [pgw_pkg::BYTE_BITS-1:0]     rsp_data_ff, rsp_data_in;

   pgw_pkg::cmd_type                  cmd;
   logic [PN-1:0]                     write_page;
   logic [OB-1:0]                     write_offset;
   logic                              load_rsp;
   logic                              translated;

   assign cmd          = pgw_pkg::cmd_type'(req.cmd);
   assign write_page   = req.write_address[pgw_pkg::WADDR_BITS-1:OB];
   assign write_offset = req.write_address[OB-1:0];

   always_comb begin
      state_in    = state_ff;
      va_in       = va_ff;
      pt_in       = pt_ff;
      pfn_in      = pfn_ff;
      resident_in = resident_ff;
      status_in   = status_ff;
      data_in     = data_ff;
      load_rsp    = 1'b0;
      req.ready   = 1'b0;
      mem_ctl     = '0;
      mem_addr    = '0;
      disk_ctl    = '0;
      disk_addr   = '0;
      unique case (state_ff)
         pgw_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               va_in = req.virt_address;
               unique case (cmd)
                  pgw_pkg::CMD_TRANSLATE: begin
                     mem_ctl.read_en = 1'b1;
                     mem_addr = {page_map[directory_base_page],
                                 req.virt_address[pgw_pkg::VADDR_BITS-1:2*OB]};
                     state_in = pgw_pkg::ST_DIRECTORY;
                  end
                  pgw_pkg::CMD_WRITE_MEMORY: begin
                     mem_ctl.write_en = 1'b1;
                     mem_ctl.wdata    = req.write_data;
                     mem_addr         = {page_map[write_page], write_offset};
                     status_in        = pgw_pkg::STATUS_WRITTEN;
                     state_in         = pgw_pkg::ST_DONE;
                  end
                  pgw_pkg::CMD_WRITE_DISK: begin
                     disk_ctl.write_en = 1'b1;
                     disk_ctl.wdata    = req.write_data;
                     disk_addr         = {page_map[write_page], write_offset};
                     status_in         = pgw_pkg::STATUS_WRITTEN;
                     state_in          = pgw_pkg::ST_DONE;
                  end
                  pgw_pkg::CMD_UNUSED: begin
                     state_in = pgw_pkg::ST_IDLE;
                  end
                  default: begin
                     state_in = pgw_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         pgw_pkg::ST_DIRECTORY: begin
            pt_in = mem_rdata[PN-1:0];
            if (mem_rdata[pgw_pkg::ENTRY_VALID_BIT]) begin
               mem_ctl.read_en = 1'b1;
               mem_addr = {page_map[mem_rdata[PN-1:0]], va_ff[2*OB-1:OB]};
               state_in = pgw_pkg::ST_TABLE;
            end else begin
               status_in = pgw_pkg::STATUS_FAULT;
               state_in  = pgw_pkg::ST_DONE;
            end
         end
         pgw_pkg::ST_TABLE: begin
            pfn_in      = mem_rdata[PN-1:0];
            resident_in = mem_rdata[pgw_pkg::ENTRY_VALID_BIT];
            mem_addr    = {page_map[mem_rdata[PN-1:0]], va_ff[OB-1:0]};
            disk_addr   = {page_map[mem_rdata[PN-1:0]], va_ff[OB-1:0]};
            if (mem_rdata[pgw_pkg::ENTRY_VALID_BIT]) begin
               mem_ctl.read_en = 1'b1;
               status_in = pgw_pkg::STATUS_MEMORY;
            end else begin
               disk_ctl.read_en = 1'b1;
               status_in = pgw_pkg::STATUS_DISK;
            end
            state_in = pgw_pkg::ST_DATA;
         end
         pgw_pkg::ST_DATA: begin
            data_in  = resident_ff ? mem_rdata : disk_rdata;
            state_in = pgw_pkg::ST_DONE;
         end
         pgw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = pgw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pgw_pkg::ST_IDLE;
         end
      endcase
   end

   // shape the response fields from the walk outcome
   always_comb begin
      translated    = (status_ff == pgw_pkg::STATUS_MEMORY) ||
                      (status_ff == pgw_pkg::STATUS_DISK);
      rsp_status_in = status_ff;
      rsp_dir_in    = '0;
      rsp_pt_in     = '0;
      rsp_pfn_in    = '0;
      rsp_paddr_in  = '0;
      rsp_data_in   = '0;
      if (status_ff != pgw_pkg::STATUS_WRITTEN) begin
         rsp_dir_in = va_ff[pgw_pkg::VADDR_BITS-1:2*OB];
         rsp_pt_in  = pt_ff;
      end
      if (translated) begin
         rsp_pfn_in   = pfn_ff;
         rsp_paddr_in = {pfn_ff, va_ff[OB-1:0]};
         rsp_data_in  = data_ff;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff       <= va_in;
      pt_ff       <= pt_in;
      pfn_ff      <= pfn_in;
      resident_ff <= resident_in;
      status_ff   <= status_in;
      data_ff     <= data_in;
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_dir_ff    <= rsp_dir_in;
         rsp_pt_ff     <= rsp_pt_in;
         rsp_pfn_ff    <= rsp_pfn_in;
         rsp_paddr_ff  <= rsp_paddr_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.directory_index = rsp_dir_ff;
   assign rsp.table_page      = rsp_pt_ff;
   assign rsp.frame_number    = rsp_pfn_ff;
   assign rsp.phys_address    = rsp_paddr_ff;
   assign rsp.data_value      = rsp_data_ff;

endmodule
